@@ hw/rtl/poa_pkg.sv @@
// Package for the prescaled oversampling averager.
// Field widths, register indexes, status codes and default parameters.
// No dependencies.
package poa_pkg;

    localparam int FIELD_W     = 32;  // width of sample and measurement fields
    localparam int STATUS_W    = 2;
    localparam int OS_W        = 4;   // oversample register and counter
    localparam int PS_W        = 16;  // prescale register and counter
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int MAX_SAMPLES_DEF = 16;
    localparam int SAMPLE_BITS_DEF = 32;

    typedef enum logic [STATUS_W-1:0] {
        ST_INACTIVE  = 2'd0,
        ST_PRESCALED = 2'd1,
        ST_SAMPLED   = 2'd2,
        ST_MEASURED  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE  = 3'd0,
        REG_OS_HIGH = 3'd1,
        REG_PS_HIGH = 3'd2,
        REG_OS_LOW  = 3'd3,
        REG_PS_LOW  = 3'd4
    } cfg_idx_t;

endpackage

@@ hw/rtl/poa_in_if.sv @@
// Input channel of the averager: one tick with power mode and sample.
// Depends on poa_pkg.
interface poa_in_if;
    logic                              valid;
    logic                              ready;
    logic                              usb_power;
    logic signed [poa_pkg::FIELD_W-1:0] sample_value;

    modport source (output valid, output usb_power, output sample_value, input ready);
    modport sink   (input valid, input usb_power, input sample_value, output ready);
endinterface

@@ hw/rtl/poa_out_if.sv @@
// Output channel of the averager: status, last stored sample and last mean.
// Depends on poa_pkg.
interface poa_out_if;
    logic                              valid;
    logic                              ready;
    logic [poa_pkg::STATUS_W-1:0]       status;
    logic signed [poa_pkg::FIELD_W-1:0] last_sample;
    logic signed [poa_pkg::FIELD_W-1:0] measurement;

    modport source (output valid, output status, output last_sample, output measurement,
                    input ready);
    modport sink   (input valid, input status, input last_sample, input measurement,
                     output ready);
endinterface

@@ hw/rtl/prescaled_oversampling_averager_top.sv @@
// Top level of the prescaled oversampling averager.
// Depends on poa_pkg, poa_in_if, poa_out_if, poa_store and poa_div.
//
// Usage:
//   in_ch  : one transfer per tick, carrying usb_power and sample_value.
//   out_ch : one transfer per tick, carrying status, last_sample, measurement.
//   cfg_*  : write port for enable and the high/low power oversample and
//            prescale registers; write only while no tick is in flight.
// Sequence:
//   A tick that does not close a measurement goes from idle to S_EMIT, which
//   loads its result into the output register once that register is free
//   and then returns to idle, where the next tick is taken. A measuring tick
//   walks the sample store (one read a cycle, N = oversample + 1 reads), then
//   passes S_DRAIN and S_DIV_START, waits in S_DIV_WAIT for the bit-serial
//   divider and loads its result in S_EMIT in the same way; the next tick
//   is taken once the datapath is back in idle.
//   One tick is in the datapath at a time; in_ch.ready is high while idle.
//   The output register decouples the sides: a new tick is taken while the
//   previous result waits, and a stalled receiver holds the next result in
//   the datapath until the output register frees.
// Reset clears the configuration registers, counters, held values, the output
// valid flag and the store's valid bits; no clearing pass is needed.
module prescaled_oversampling_averager_top #(
    parameter int MAX_SAMPLES = poa_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = poa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [poa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [poa_pkg::CFG_DATA_W-1:0]  cfg_data,
    poa_in_if.sink                          in_ch,
    poa_out_if.source                       out_ch
);

    localparam int IDX_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int OS_CAP  = MAX_SAMPLES - 1;
    localparam int CNT_MAX = (MAX_SAMPLES < 16) ? MAX_SAMPLES : 16;
    localparam int SUM_W   = SAMPLE_BITS + $clog2(CNT_MAX) + 1;
    localparam int DEN_W   = $clog2(CNT_MAX + 1);
    localparam int OS_W    = poa_pkg::OS_W;
    localparam int PS_W    = poa_pkg::PS_W;
    localparam int FIELD_W = poa_pkg::FIELD_W;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_READ      = 6'b000010,
        S_DRAIN     = 6'b000100,
        S_DIV_START = 6'b001000,
        S_DIV_WAIT  = 6'b010000,
        S_EMIT      = 6'b100000
    } state_t;

    // configuration registers
    logic            enable_reg;
    logic [OS_W-1:0] os_high_reg;
    logic [PS_W-1:0] ps_high_reg;
    logic [OS_W-1:0] os_low_reg;
    logic [PS_W-1:0] ps_low_reg;

    // datapath state
    state_t                        state_reg, state_next;
    logic [PS_W-1:0]               ps_count_reg, ps_count_next;
    logic [OS_W-1:0]               os_count_reg, os_count_next;
    logic [OS_W-1:0]               os_lim_reg, os_lim_next;
    logic [OS_W-1:0]               rd_idx_reg, rd_idx_next;
    logic                          rd_vld_reg;
    logic signed [SUM_W-1:0]       acc_reg, acc_next;
    logic signed [SAMPLE_BITS-1:0] held_sample_reg, held_sample_next;
    logic signed [SAMPLE_BITS-1:0] held_meas_reg, held_meas_next;
    poa_pkg::status_t              status_reg, status_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [poa_pkg::STATUS_W-1:0]  out_status_reg;
    logic signed [FIELD_W-1:0]     out_sample_reg;
    logic signed [FIELD_W-1:0]     out_meas_reg;

    // tick evaluation
    logic                          in_fire;
    logic                          out_load;
    logic [OS_W-1:0]               os_lim;
    logic [PS_W-1:0]               ps_lim;
    logic [OS_W-1:0]               os_c;
    logic [PS_W-1:0]               ps_c;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    // store and divider connections
    logic                          st_we;
    logic                          st_re;
    logic signed [SAMPLE_BITS-1:0] st_rdata;
    logic                          div_start;
    logic                          div_done;
    logic signed [SUM_W-1:0]       div_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            os_high_reg <= '0;
            ps_high_reg <= '0;
            os_low_reg  <= '0;
            ps_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (poa_pkg::cfg_idx_t'(cfg_index))
                poa_pkg::REG_ENABLE:  enable_reg  <= cfg_data[0];
                poa_pkg::REG_OS_HIGH: os_high_reg <= cfg_data[OS_W-1:0];
                poa_pkg::REG_PS_HIGH: ps_high_reg <= cfg_data[PS_W-1:0];
                poa_pkg::REG_OS_LOW:  os_low_reg  <= cfg_data[OS_W-1:0];
                poa_pkg::REG_PS_LOW:  ps_low_reg  <= cfg_data[PS_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_fire   = in_ch.valid && (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || out_ch.ready);
    assign sample_in = in_ch.sample_value[SAMPLE_BITS-1:0];

    // limits for the selected power mode, counters clamped to them
    always_comb
    begin
        os_lim = in_ch.usb_power ? os_high_reg : os_low_reg;
        ps_lim = in_ch.usb_power ? ps_high_reg : ps_low_reg;
        if (int'(os_lim) > OS_CAP)
        begin
            os_lim = OS_W'(OS_CAP);
        end
        ps_c = (ps_count_reg > ps_lim) ? ps_lim : ps_count_reg;
        os_c = (os_count_reg > os_lim) ? os_lim : os_count_reg;
    end

    always_comb
    begin
        state_next       = state_reg;
        ps_count_next    = ps_count_reg;
        os_count_next    = os_count_reg;
        os_lim_next      = os_lim_reg;
        rd_idx_next      = rd_idx_reg;
        acc_next         = acc_reg;
        held_sample_next = held_sample_reg;
        held_meas_next   = held_meas_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg;
        st_we            = 1'b0;
        st_re            = 1'b0;
        div_start        = 1'b0;

        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (rd_vld_reg)
        begin
            acc_next = acc_reg + SUM_W'(st_rdata);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EMIT;
                    if (!enable_reg)
                    begin
                        status_next = poa_pkg::ST_INACTIVE;
                    end
                    else if (ps_c != '0)
                    begin
                        ps_count_next = ps_c - 1'b1;
                        os_count_next = os_c;
                        status_next   = poa_pkg::ST_PRESCALED;
                    end
                    else
                    begin
                        ps_count_next    = ps_lim;
                        held_sample_next = sample_in;
                        st_we            = 1'b1;
                        if (os_c == '0)
                        begin
                            os_count_next = os_lim;
                            os_lim_next   = os_lim;
                            rd_idx_next   = '0;
                            acc_next      = '0;
                            status_next   = poa_pkg::ST_MEASURED;
                            state_next    = S_READ;
                        end
                        else
                        begin
                            os_count_next = os_c - 1'b1;
                            status_next   = poa_pkg::ST_SAMPLED;
                        end
                    end
                end
            end
            S_READ:
            begin
                st_re = 1'b1;
                if (rd_idx_reg == os_lim_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    held_meas_next = div_quo[SAMPLE_BITS-1:0];
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ps_count_reg    <= '0;
            os_count_reg    <= '0;
            os_lim_reg      <= '0;
            rd_idx_reg      <= '0;
            rd_vld_reg      <= 1'b0;
            acc_reg         <= '0;
            held_sample_reg <= '0;
            held_meas_reg   <= '0;
            status_reg      <= poa_pkg::ST_INACTIVE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ps_count_reg    <= ps_count_next;
            os_count_reg    <= os_count_next;
            os_lim_reg      <= os_lim_next;
            rd_idx_reg      <= rd_idx_next;
            rd_vld_reg      <= st_re;
            acc_reg         <= acc_next;
            held_sample_reg <= held_sample_next;
            held_meas_reg   <= held_meas_next;
            status_reg      <= status_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_sample_reg <= FIELD_W'(held_sample_reg);
            out_meas_reg   <= FIELD_W'(held_meas_reg);
        end
    end

    poa_store #(
        .DEPTH  (MAX_SAMPLES),
        .DATA_W (SAMPLE_BITS),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (st_we),
        .waddr (IDX_W'(os_c)),
        .wdata (sample_in),
        .re    (st_re),
        .raddr (IDX_W'(rd_idx_reg)),
        .rdata (st_rdata)
    );

    poa_div #(
        .SUM_W (SUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (DEN_W'({1'b0, os_lim_reg} + 1'b1)),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_ch.ready        = (state_reg == S_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.last_sample = out_sample_reg;
    assign out_ch.measurement = out_meas_reg;

    // oversample counter always indexes inside the store
    a_os_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        int'(os_count_reg) <= OS_CAP)
        else $error("oversample counter beyond store");

    // store walk never passes the measurement's limit
    a_rd_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (rd_idx_reg <= os_lim_reg))
        else $error("store read beyond oversample limit");

    // divider finishes only while it is being waited on
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider done outside wait state");

    // an accepted tick takes the datapath out of idle
    a_busy_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != S_IDLE))
        else $error("tick accepted but datapath stayed idle");

    // store is written only on an accepted tick
    a_write_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> (in_fire && enable_reg))
        else $error("store written without an accepted tick");

endmodule

@@ hw/rtl/poa_store.sv @@
// Sample store: single-port-write, registered-read memory with per-entry
// valid bits so that unwritten entries read as zero after reset. No package use.
module poa_store #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic                     re,
    input  logic [ADDR_W-1:0]        raddr,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DEPTH-1:0]         valid_reg;
    logic signed [DATA_W-1:0] rdata_reg;
    logic                     rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

@@ hw/rtl/poa_div.sv @@
// Serial restoring divider, one quotient bit per cycle, truncating toward zero.
// Signed dividend, positive unsigned divisor. No package use.
module poa_div #(
    parameter int SUM_W = 37,
    parameter int DEN_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [DEN_W-1:0]        divisor,
    output logic                    done,
    output logic signed [SUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [SUM_W-1:0] quo_reg;
    logic             neg_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            neg_reg <= dividend[SUM_W-1];
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

@@ dv/prescaled_oversampling_averager_top_tb.sv @@
// Self-checking testbench for prescaled_oversampling_averager_top.
// A directed table, then random phases, checked by typed results or a predictor.
// Depends on poa_pkg, poa_in_if, poa_out_if and the averager RTL.
module prescaled_oversampling_averager_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_W    = poa_pkg::FIELD_W;
    localparam int CFG_IDX_W  = poa_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = poa_pkg::CFG_DATA_W;
    localparam int OS_W       = poa_pkg::OS_W;
    localparam int PS_W       = poa_pkg::PS_W;

    typedef struct packed {
        poa_pkg::status_t           status;
        logic signed [FIELD_W-1:0]  last_sample;
        logic signed [FIELD_W-1:0]  measurement;
    } tick_result_t;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_DATA_W-1:0]      data;
        logic                       usb;
        logic signed [FIELD_W-1:0]  sample;
        logic                       typed;
        tick_result_t               res;
    } dir_row_t;

    // indexes past the register file; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_C = 3'd7;

    localparam logic [CFG_IDX_W-1:0] R_EN   = poa_pkg::REG_ENABLE;
    localparam logic [CFG_IDX_W-1:0] R_OS_H = poa_pkg::REG_OS_HIGH;
    localparam logic [CFG_IDX_W-1:0] R_PS_H = poa_pkg::REG_PS_HIGH;
    localparam logic [CFG_IDX_W-1:0] R_OS_L = poa_pkg::REG_OS_LOW;
    localparam logic [CFG_IDX_W-1:0] R_PS_L = poa_pkg::REG_PS_LOW;

    localparam logic signed [FIELD_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [FIELD_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
    localparam tick_result_t NO_RES = '{poa_pkg::ST_INACTIVE, 32'sd0, 32'sd0};
    localparam int STORE_DEPTH = poa_pkg::MAX_SAMPLES_DEF;
    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES = 400;
    localparam int ROWS = 33;

    localparam dir_row_t DIRECTED_ROWS [ROWS] = '{
        // channel disabled after reset
        '{ROW_TICK, R_EN, 16'd0, 1'b0, 32'sd5, 1'b1, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b1, -32'sd1, 1'b1, NO_RES},
        '{ROW_CFG, R_EN, 16'd1, 1'b0, 32'sd0, 1'b0, NO_RES},
        // zero limits: every tick measures its own sample
        '{ROW_TICK, R_EN, 16'd0, 1'b0, SAMPLE_MAX, 1'b1,
          '{poa_pkg::ST_MEASURED, SAMPLE_MAX, SAMPLE_MAX}},
        '{ROW_TICK, R_EN, 16'd0, 1'b1, SAMPLE_MIN, 1'b1,
          '{poa_pkg::ST_MEASURED, SAMPLE_MIN, SAMPLE_MIN}},
        // oversample written out of range, prescale at its top
        '{ROW_CFG, R_OS_H, 16'hFFFF, 1'b0, 32'sd0, 1'b0, NO_RES},
        '{ROW_CFG, R_PS_H, 16'hFFFF, 1'b0, 32'sd0, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b1, 32'sd1, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b1, 32'sd7, 1'b0, NO_RES},
        // drop to battery: counters clamp to zero, measure at once
        '{ROW_TICK, R_EN, 16'd0, 1'b0, -32'sd3, 1'b1,
          '{poa_pkg::ST_MEASURED, -32'sd3, -32'sd3}},
        // negative odd sums: division truncates toward zero
        '{ROW_CFG, R_OS_L, 16'd1, 1'b0, 32'sd0, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b0, -32'sd3, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b0, -32'sd4, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b0, -32'sd3, 1'b0, NO_RES},
        '{ROW_CFG, R_PS_L, 16'd2, 1'b0, 32'sd0, 1'b0, NO_RES},
        '{ROW_CFG, R_OS_L, 16'd3, 1'b0, 32'sd0, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b0, 32'sd100, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b0, 32'sd200, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b0, -32'sd300, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b0, 32'sd400, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b0, 32'sd500, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b0, 32'sd600, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b0, 32'sd700, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b1, 32'sd12345, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b0, -32'sd77, 1'b0, NO_RES},
        '{ROW_CFG, IDX_SPARE_A, 16'hFFFF, 1'b0, 32'sd0, 1'b0, NO_RES},
        '{ROW_CFG, IDX_SPARE_B, 16'hFFFF, 1'b0, 32'sd0, 1'b0, NO_RES},
        '{ROW_CFG, IDX_SPARE_C, 16'hFFFF, 1'b0, 32'sd0, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b0, 32'sd9, 1'b0, NO_RES},
        // only bit 0 of enable counts
        '{ROW_CFG, R_EN, 16'hFFFE, 1'b0, 32'sd0, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b1, 32'sd77, 1'b0, NO_RES},
        '{ROW_CFG, R_EN, 16'd1, 1'b0, 32'sd0, 1'b0, NO_RES},
        '{ROW_TICK, R_EN, 16'd0, 1'b1, SAMPLE_MAX, 1'b0, NO_RES}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    poa_in_if  in_ch ();
    poa_out_if out_ch ();

    prescaled_oversampling_averager_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor state
    logic                       en_r = 1'b0;
    logic [OS_W-1:0]            os_hi_r = '0;
    logic [PS_W-1:0]            ps_hi_r = '0;
    logic [OS_W-1:0]            os_lo_r = '0;
    logic [PS_W-1:0]            ps_lo_r = '0;
    logic [PS_W-1:0]            ps_cnt = '0;
    logic [OS_W-1:0]            os_cnt = '0;
    logic signed [FIELD_W-1:0]  store_r [STORE_DEPTH] = '{default: '0};
    logic signed [FIELD_W-1:0]  held_sample_r = '0;
    logic signed [FIELD_W-1:0]  held_meas_r = '0;

    tick_result_t   pending_results [$];
    tick_result_t   want;
    int             mismatches = 0;
    int             live_ticks = 0;
    int             rx_hold_left = 0;
    bit             quiet = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("prescaled_oversampling_averager_top regression: fail");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        if (mismatches < 60)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic [PS_W-1:0] pick_prescale();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 16'hFFFF : 16'($urandom);
            1: return 16'($urandom_range(24, 4));
            default: return 16'($urandom_range(3));
        endcase
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            poa_pkg::REG_ENABLE:  en_r = data[0];
            poa_pkg::REG_OS_HIGH: os_hi_r = data[OS_W-1:0];
            poa_pkg::REG_PS_HIGH: ps_hi_r = data[PS_W-1:0];
            poa_pkg::REG_OS_LOW:  os_lo_r = data[OS_W-1:0];
            poa_pkg::REG_PS_LOW:  ps_lo_r = data[PS_W-1:0];
            default: ;
        endcase
    endfunction

    // one tick through the averager; updates the predictor state
    function automatic tick_result_t averager_tick(input logic usb,
                                                   input logic signed [FIELD_W-1:0] sample);
        logic [OS_W-1:0] os_lim;
        logic [PS_W-1:0] ps_lim;
        longint          sum;
        longint          divisor;
        int              i;
        tick_result_t    r;
        if (!en_r)
            r.status = poa_pkg::ST_INACTIVE;
        else
        begin
            // a 4-bit limit never exceeds the 16-entry store
            os_lim = usb ? os_hi_r : os_lo_r;
            ps_lim = usb ? ps_hi_r : ps_lo_r;
            if (ps_cnt > ps_lim)
                ps_cnt = ps_lim;
            if (os_cnt > os_lim)
                os_cnt = os_lim;
            if (ps_cnt == 0)
            begin
                ps_cnt = ps_lim;
                held_sample_r = sample;
                store_r[os_cnt] = sample;
                if (os_cnt == 0)
                begin
                    sum = 0;
                    for (i = 0; i <= int'(os_lim); i++)
                        sum += store_r[i];
                    divisor = longint'(os_lim) + 1;
                    held_meas_r = FIELD_W'(sum / divisor);
                    os_cnt = os_lim;
                    r.status = poa_pkg::ST_MEASURED;
                end
                else
                begin
                    os_cnt--;
                    r.status = poa_pkg::ST_SAMPLED;
                end
            end
            else
            begin
                ps_cnt--;
                r.status = poa_pkg::ST_PRESCALED;
            end
        end
        r.last_sample = held_sample_r;
        r.measurement = held_meas_r;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_tick(input logic usb, input logic signed [FIELD_W-1:0] sample,
                             input logic typed, input tick_result_t typed_res);
        tick_result_t predicted;
        while (!quiet && $urandom_range(99) < 19)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.usb_power    <= usb;
        in_ch.sample_value <= sample;
        do
            @(posedge clk);
        while (!in_ch.ready);
        live_ticks++;
        predicted = averager_tick(usb, sample);
        pending_results.push_back(typed ? typed_res : predicted);
        @(negedge clk);
    endtask

    // stop offering and wait until every result has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // receiver: random back-pressure, with a counted hold-off on request
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end
        else if (quiet)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(99) >= 19);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
                note_mismatch("result transfer with nothing pending");
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.status !== want.status)
                    note_mismatch($sformatf("status %0d, want %0d",
                                            out_ch.status, want.status));
                if (out_ch.last_sample !== want.last_sample)
                    note_mismatch($sformatf("last_sample %0d, want %0d",
                                            out_ch.last_sample, want.last_sample));
                if (out_ch.measurement !== want.measurement)
                    note_mismatch($sformatf("measurement %0d, want %0d",
                                            out_ch.measurement, want.measurement));
            end
        end
    end

    initial
    begin
        int            phase;
        int            n;
        int            k;
        int            mode_style;
        logic          usb;
        logic          en_bit;
        logic signed [FIELD_W-1:0] sample;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.usb_power    = 1'b0;
        in_ch.sample_value = '0;
        out_ch.ready       = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (k = 0; k < ROWS; k++)
        begin
            if (DIRECTED_ROWS[k].kind == ROW_CFG)
            begin
                drain();
                write_reg(DIRECTED_ROWS[k].idx, DIRECTED_ROWS[k].data);
            end
            else
                send_tick(DIRECTED_ROWS[k].usb, DIRECTED_ROWS[k].sample,
                          DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].res);
        end

        phase = 0;
        live_ticks = 0;
        while (live_ticks < RANDOM_ITEMS)
        begin
            // sender pause: everything outstanding comes back before reconfiguring
            drain();
            en_bit = ($urandom_range(9) != 0);
            write_reg(R_EN, {15'($urandom), en_bit});
            write_reg(R_OS_H, ($urandom_range(7) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(15)));
            write_reg(R_PS_H, pick_prescale());
            write_reg(R_OS_L, ($urandom_range(7) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(15)));
            write_reg(R_PS_L, pick_prescale());
            if ($urandom_range(3) == 0)
                write_reg(CFG_IDX_W'(IDX_SPARE_A + $urandom_range(2)), 16'($urandom));

            quiet = (phase == 3);
            n = $urandom_range(80, 20);
            if (phase == 5)
            begin
                // long receiver hold-off while ticks keep coming; input must stall
                rx_hold_left = HOLD_CYCLES;
                n = 60;
            end
            mode_style = $urandom_range(2);
            usb = 1'($urandom_range(1));
            for (k = 0; k < n; k++)
            begin
                case (mode_style)
                    0: if ($urandom_range(19) == 0) usb = ~usb;
                    1: usb = 1'($urandom_range(1));
                    default: if ($urandom_range(49) == 0) usb = ~usb;
                endcase
                case ($urandom_range(7))
                    0: sample = SAMPLE_MAX;
                    1: sample = SAMPLE_MIN;
                    2: sample = $urandom_range(1) ? 32'sd0 : -32'sd1;
                    3, 4: sample = FIELD_W'($urandom_range(200)) - 32'sd100;
                    default: sample = $urandom;
                endcase
                send_tick(usb, sample, 1'b0, NO_RES);
            end
            quiet = 1'b0;
            phase++;
        end

        drain();
        repeat (64) @(negedge clk);
        if (mismatches == 0)
            $display("prescaled_oversampling_averager_top regression: pass");
        else
            $display("prescaled_oversampling_averager_top regression: fail");
        $finish;
    end

endmodule
